FILE: rtl/sha256_byte_stream_hasher_assert.svh
// assertion macros for the sha-256 stream hasher
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
// property that holds on every clock edge outside reset
`define SHA_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property checked on all edges including reset
`define SHA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: rtl/sha_pkg.sv
// -----------------------------------------------------------------------------
// sha_pkg
// constants and helpers shared by the sha-256 stream hasher
// -----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;
   localparam int unsigned BlockBytes = 64;
   localparam int unsigned ByteAw     = 6;
   localparam int unsigned Rounds     = 64;

   typedef logic [31:0] word_type;

   typedef enum logic [0:0] {
      CMD_ABSORB = 1'b0,
      CMD_FINISH = 1'b1
   } cmd_type;

   function automatic word_type round_k(input logic [5:0] r);
      word_type k;
      begin
         case (r)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
         endcase
         return k;
      end
   endfunction

   function automatic word_type init_word(input logic [2:0] i);
      word_type h;
      begin
         case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
         endcase
         return h;
      end
   endfunction
endpackage
`default_nettype wire

FILE: rtl/sha_ram.sv
// -----------------------------------------------------------------------------
// sha_ram
// generic single-port-write, single-port-read ram with registered read
// -----------------------------------------------------------------------------
`default_nettype none
module sha_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: rtl/sha_round.sv
// -----------------------------------------------------------------------------
// sha_round
// one sha-256 round and one message schedule step, combinational
// -----------------------------------------------------------------------------
`default_nettype none
module sha_round (
   input  wire logic [7:0][31:0] v_in,
   input  wire logic [31:0]      w_cur,
   input  wire logic [31:0]      k_cur,
   input  wire logic [15:0][31:0] win,
   output logic      [7:0][31:0] v_out,
   output logic      [31:0]      w_next
);
   import sha_pkg::*;

   function automatic word_type ror(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   word_type big0, big1, ch, maj, t1, t2, s0, s1;

   // compression round
   always_comb begin
      big1 = ror(v_in[4], 6) ^ ror(v_in[4], 11) ^ ror(v_in[4], 25);
      ch   = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
      t1   = v_in[7] + big1 + ch + k_cur + w_cur;
      big0 = ror(v_in[0], 2) ^ ror(v_in[0], 13) ^ ror(v_in[0], 22);
      maj  = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
      t2   = big0 + maj;
      v_out[7] = v_in[6];
      v_out[6] = v_in[5];
      v_out[5] = v_in[4];
      v_out[4] = v_in[3] + t1;
      v_out[3] = v_in[2];
      v_out[2] = v_in[1];
      v_out[1] = v_in[0];
      v_out[0] = t1 + t2;
   end

   // schedule word sixteen ahead: win[0] is w[r], win[15] is w[r+15]
   always_comb begin
      s0 = ror(win[1], 7) ^ ror(win[1], 18) ^ (win[1] >> 3);
      s1 = ror(win[14], 17) ^ ror(win[14], 19) ^ (win[14] >> 10);
      w_next = s1 + win[9] + s0 + win[0];
   end
endmodule
`default_nettype wire

FILE: rtl/sha256_byte_stream_hasher.sv
// -----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// streaming sha-256: message bytes in, eight digest words out
// -----------------------------------------------------------------------------
// usage:
//   req channel: req_command absorb (0) with req_data_byte, or finish (1).
//   rsp channel: eight beats per finish, rsp_word_index 0..7, rsp_last_word on 7.
//   absorb bytes are written to the byte ram; the 64th byte of a block starts
//   the loader (reading the byte ram, one byte a cycle, into the schedule
//   window), then the rounds of the single round unit and the chaining add.
//   a finish writes the pad bytes one per cycle into the byte ram, runs one
//   or two blocks and then emits the digest words, one per cycle while
//   rsp_ready is high.
//   req_ready is low while padding, while a block is loaded or compressed
//   and while the digest drains.
//   a stalled receiver simply holds the rsp beat; nothing is lost.
//   reset (synchronous) restores the initial hash value and empties the
//   block; the byte ram needs no clearing since unwritten bytes are never read.
// -----------------------------------------------------------------------------
`default_nettype none
module sha256_byte_stream_hasher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [0:0]  req_command,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);
   import sha_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PAD   = 6'b000010,
      ST_LOAD  = 6'b000100,
      ST_ROUND = 6'b001000,
      ST_ADD   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [5:0]        count_ff, count_in;      // bytes pending
   logic [63:0]       bits_ff, bits_in;        // compressed bits
   logic [63:0]       total_ff, total_in;      // length for padding
   logic              final_ff, final_in;      // compressing a finish block
   logic [5:0]        pad_ff, pad_in;          // pad write pointer
   logic [6:0]        step_ff, step_in;        // load/round counter
   logic [7:0][31:0]  chain_ff, chain_in;
   logic [7:0][31:0]  v_ff, v_in;
   logic [15:0][31:0] win_ff, win_in;
   logic [2:0]        oidx_ff, oidx_in;

   logic              wr_en;
   logic [5:0]        wr_addr, rd_addr;
   logic [7:0]        wr_data, rd_data;
   logic [7:0][31:0]  v_next;
   logic [31:0]       w_next;
   logic              rd_live_ff, rd_live_in;

   sha_ram #(.Width(8), .Depth(BlockBytes)) u_bytes (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   sha_round u_round (
      .v_in  (v_ff),
      .w_cur (win_ff[0]),
      .k_cur (round_k(step_ff[5:0])),
      .win   (win_ff),
      .v_out (v_next),
      .w_next(w_next)
   );

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = chain_ff[oidx_ff];
   assign rsp_word_index  = oidx_ff;
   assign rsp_last_word   = (oidx_ff == 3'd7);

   // control and datapath next state
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      bits_in    = bits_ff;
      total_in   = total_ff;
      final_in   = final_ff;
      pad_in     = pad_ff;
      step_in    = step_ff;
      chain_in   = chain_ff;
      v_in       = v_ff;
      win_in     = win_ff;
      oidx_in    = oidx_ff;
      wr_en      = 1'b0;
      wr_addr    = count_ff;
      wr_data    = req_data_byte;
      rd_addr    = step_ff[5:0];
      rd_live_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               wr_en = 1'b1;
               if (req_command == CMD_ABSORB) begin
                  count_in = count_ff + 6'd1;
                  if (count_ff == 6'd63) begin
                     final_in = 1'b0;
                     step_in  = '0;
                     state_in = ST_LOAD;
                  end
               end else begin
                  wr_data  = 8'h80;
                  total_in = bits_ff + {55'd0, count_ff, 3'd0};
                  pad_in   = count_ff + 6'd1;
                  final_in = 1'b1;
                  state_in = ST_PAD;
                  if (count_ff == 6'd63) begin
                     step_in  = '0;
                     final_in = 1'b0;
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         ST_PAD: begin
            // zeros then big-endian length in bytes 56..63
            wr_en   = 1'b1;
            wr_addr = pad_ff;
            if (pad_ff < 6'd56 && count_ff <= 6'd55) begin
               wr_data = 8'h00;
            end else if (count_ff > 6'd55) begin
               wr_data = 8'h00;
            end else begin
               wr_data = total_ff[8'd63 - {2'd0, pad_ff[2:0], 3'd0} -: 8];
            end
            pad_in = pad_ff + 6'd1;
            if (pad_ff == 6'd63) begin
               step_in  = '0;
               final_in = (count_ff <= 6'd55);
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // stream bytes into the window, one per cycle after ram latency;
            // a new word starts in slot 15 and earlier words move down
            rd_addr    = step_ff[5:0];
            rd_live_in = (step_ff < 7'd64);
            if (rd_live_ff) begin
               if (step_ff[1:0] == 2'd1) begin
                  win_in = {{24'd0, rd_data}, win_ff[15:1]};
               end else begin
                  win_in[15] = {win_ff[15][23:0], rd_data};
               end
            end
            step_in = step_ff + 7'd1;
            if (step_ff == 7'd64) begin
               v_in     = chain_ff;
               step_in  = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            v_in    = v_next;
            win_in  = {w_next, win_ff[15:1]};
            step_in = step_ff + 7'd1;
            if (step_ff == 7'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + v_ff[i];
            end
            bits_in = bits_ff + 64'd512;
            if (final_ff) begin
               oidx_in  = '0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_IDLE;
            end
            // second pad block after an overflowing finish
            if (!final_ff && count_ff != 6'd0) begin
               count_in = 6'd0;
               pad_in   = 6'd0;
               wr_en    = 1'b1;
               wr_addr  = 6'd0;
               wr_data  = 8'h00;
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) begin
                     chain_in[i] = init_word(3'(i));
                  end
                  count_in = '0;
                  bits_in  = '0;
                  final_in = 1'b0;
                  pad_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         bits_ff    <= '0;
         final_ff   <= 1'b0;
         pad_ff     <= '0;
         step_ff    <= '0;
         oidx_ff    <= '0;
         rd_live_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= init_word(3'(i));
         end
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         bits_ff    <= bits_in;
         final_ff   <= final_in;
         pad_ff     <= pad_in;
         step_ff    <= step_in;
         oidx_ff    <= oidx_in;
         rd_live_ff <= rd_live_in;
         chain_ff   <= chain_in;
      end
      total_ff <= total_in;
      v_ff     <= v_in;
      win_ff   <= win_in;
   end
endmodule
`default_nettype wire

FILE: rtl/sha_checker.sv
// -----------------------------------------------------------------------------
// sha_checker
// port-level checks for the sha-256 stream hasher
// -----------------------------------------------------------------------------
`default_nettype none
`include "sha256_byte_stream_hasher_assert.svh"
module sha_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_digest_word,
   input wire logic [2:0]  rsp_word_index,
   input wire logic        rsp_last_word
);
   // last flag marks word seven only
   `SHA_ASSERT_CLK(a_last_idx, clock, reset, !rsp_valid || (rsp_last_word == (rsp_word_index == 3'd7)), "last flag mismatch")
   // no new bytes taken while digest drains
   `SHA_ASSERT_CLK(a_no_overlap, clock, reset, !(rsp_valid && req_ready), "req taken during digest")
   // word index advances after each beat within a digest
   `SHA_ASSERT_CLK(a_idx_step, clock, reset, (rsp_valid && rsp_ready && !rsp_last_word) |=> (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1), "index skip")
   // a stalled beat holds its word
   `SHA_ASSERT_CLK(a_hold, clock, reset, (rsp_valid && !rsp_ready) |=> $stable(rsp_digest_word), "word changed under stall")
endmodule

bind sha256_byte_stream_hasher sha_checker u_sha_checker (.*);
`default_nettype wire

FILE: sim/testbench.sv
// -----------------------------------------------------------------------------
// sha-256 byte stream hasher testbench
// drives message bytes and finish beats, predicts each digest with an
// independent sha-256 model and checks every digest word as it drains
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class digest_scoreboard;
   logic [7:0]  msg_block[64];
   int unsigned fill;
   logic [63:0] bit_total;
   logic [31:0] chain[8];
   logic [31:0] want_word[$];
   logic [2:0]  want_index[$];
   logic        want_last[$];
   int unsigned errors;

   function new();
      errors = 0;
      restart();
   endfunction

   function void restart();
      fill = 0;
      bit_total = '0;
      for (int i = 0; i < 8; i++) chain[i] = sha_pkg::init_word(i[2:0]);
   endfunction

   function logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function logic [31:0] kconst(int r);
      logic [31:0] table_k[64] = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
         32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
         32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
         32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
         32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return table_k[r];
   endfunction

   // one 64-round compression of msg_block into chain
   function void compress();
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2, s0, s1;
      for (int r = 0; r < 16; r++)
         w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
      for (int r = 16; r < 64; r++) begin
         s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
         s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
         w[r] = s1 + w[r-7] + s0 + w[r-16];
      end
      v = chain;
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(r) + w[r];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int j = 7; j > 0; j--) v[j] = v[j-1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++) chain[j] += v[j];
   endfunction

   // note an accepted request beat
   function void note_request(sha_pkg::cmd_type cmd, logic [7:0] data);
      logic [63:0] len;
      int unsigned i;
      if (cmd == sha_pkg::CMD_ABSORB) begin
         msg_block[fill] = data;
         fill++;
         if (fill == 64) begin
            compress();
            fill = 0;
            bit_total += 64'd512;
         end
         return;
      end
      len = bit_total + 64'(fill) * 8;
      i = fill;
      msg_block[i++] = 8'h80;
      if (i > 56) begin
         while (i < 64) msg_block[i++] = 8'h00;
         compress();
         i = 0;
      end
      while (i < 56) msg_block[i++] = 8'h00;
      for (int b = 0; b < 8; b++) msg_block[56+b] = len[63-8*b -: 8];
      compress();
      for (int j = 0; j < 8; j++) begin
         want_word.push_back(chain[j]);
         want_index.push_back(j[2:0]);
         want_last.push_back(j == 7);
      end
      restart();
   endfunction

   // compare one digest beat with the oldest pending word
   function void check_word(logic [31:0] word, logic [2:0] index, logic last);
      logic [31:0] ew;
      logic [2:0]  ei;
      logic        el;
      if (want_word.size() == 0) begin
         $error("unexpected digest beat word=%h index=%0d", word, index);
         errors++;
         return;
      end
      ew = want_word.pop_front();
      ei = want_index.pop_front();
      el = want_last.pop_front();
      if (word !== ew) begin
         $error("digest_word expected %h actual %h", ew, word);
         errors++;
      end
      if (index !== ei) begin
         $error("word_index expected %0d actual %0d", ei, index);
         errors++;
      end
      if (last !== el) begin
         $error("last_word expected %0d actual %0d", el, last);
         errors++;
      end
   endfunction

   function int pending();
      return want_word.size();
   endfunction
endclass

module testbench;
   import sha_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [0:0]  req_command = CMD_ABSORB;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   digest_scoreboard board = new();
   bit hold_rsp = 1'b0;
   bit stim_done = 1'b0;
   int unsigned sent = 0;

   sha256_byte_stream_hasher dut (.*);

   always #5 clock = ~clock;

   // mostly short gaps, a few long ones, some none
   function automatic int gap_len();
      int p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // valid stays high across back-to-back beats and drops only for a gap
   task automatic send_beat(cmd_type cmd, logic [7:0] data);
      int g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_data_byte <= data;
      do @(posedge clock); while (!req_ready);
      board.note_request(cmd, data);
      sent++;
   endtask

   task automatic send_message(int unsigned len, int mode);
      for (int i = 0; i < len; i++)
         case (mode)
            0: send_beat(CMD_ABSORB, 8'h00);
            1: send_beat(CMD_ABSORB, 8'hff);
            default: send_beat(CMD_ABSORB, 8'($urandom));
         endcase
      send_beat(CMD_FINISH, 8'($urandom));
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // result side: random stalls, long hold when requested
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_word(rsp_digest_word, rsp_word_index, rsp_last_word);
   end

   initial begin
      int g;
      @(posedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         g = gap_len();
         if (g > 0) begin
            rsp_ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // stimulus
   initial begin
      int unsigned len;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // empty message, finish with data bits set
      send_beat(CMD_FINISH, 8'hff);
      // short extremes
      send_message(1, 0);
      send_message(3, 1);
      send_message(2, 2);
      // pause until every digest word is out
      drain_all();
      // receiver holds off while further finish beats wait for the digest to drain
      hold_rsp = 1'b1;
      send_beat(CMD_FINISH, 8'h00);
      send_beat(CMD_FINISH, 8'h5a);
      send_message(1, 2);
      drain_all();
      // padding boundaries: 56, 63 and 64 bytes need two final blocks or a full one
      send_message(56, 2);
      send_message(63, 1);
      send_message(64, 0);
      while (sent < 220) begin
         len = $urandom_range(0, 12);
         send_message(len, 2);
      end
      drain_all();
      repeat (300) @(posedge clock);
      stim_done = 1'b1;
      if (board.errors == 0 && board.pending() == 0)
         $display("** sha256_byte_stream_hasher: PASSED **");
      else
         $display("** sha256_byte_stream_hasher: FAILED **");
      $finish;
   end

   initial begin
      #20ms;
      if (!stim_done) begin
         $display("** sha256_byte_stream_hasher: FAILED **");
         $finish;
      end
   end
endmodule
`default_nettype wire
